/* rtl/assert_macros.svh */
// assertion helpers for the checker file spa_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SPA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("slot pool check failed");

// next-cycle implication, disabled while reset is asserted
`define SPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("slot pool check failed");

`endif

/* rtl/spa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package spa_pkg;

  // used bitmap is kept as words of WORD_W slots; BIT_W bits index a slot within a word
  localparam int BIT_W  = 4;
  localparam int WORD_W = 1 << BIT_W;

  // request codes
  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_UPDATE = 3'b010,
    ST_SCAN   = 3'b100
  } spa_state_t;

  // search result for one bitmap word
  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] bit_idx;
  } spa_find_t;

endpackage

`default_nettype wire

/* rtl/slot_pool_allocator.sv */
`timescale 1ns / 1ps
`default_nettype none

// Clear, unknown and immediately failing requests: result registered on accept, and the
// next item may follow at once. Free and allocate at the mark: one read-modify-write of a
// bitmap word, read on accept, written back and answered in UPDATE. Allocate into a hole:
// word scan in SCAN, at most ceil(POOL_SLOTS/16) words, read in turn from the bitmap RAM.
// Synchronous active-low reset clears mark, hole count and control; the bitmap is not cleared.
// The receiver cannot stall: out_valid marks each result for exactly one cycle.
module slot_pool_allocator #(
  parameter int POOL_SLOTS = 64,
  parameter int SLOT_W     = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1,
  parameter int CNT_W      = $clog2(POOL_SLOTS + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        in_kind,
  input  wire logic [SLOT_W-1:0] in_slot,
  output logic                   out_valid,
  output logic                   out_ok,
  output logic      [SLOT_W-1:0] out_granted_slot,
  output logic      [CNT_W-1:0]  out_high_water,
  output logic      [CNT_W-1:0]  out_hole_count
);

  import spa_pkg::*;

  localparam int WORDS   = (POOL_SLOTS + WORD_W - 1) / WORD_W;
  localparam int WADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int IDX_W   = WADDR_W + BIT_W;
  localparam logic [IDX_W:0] POOL_X = (IDX_W + 1)'(POOL_SLOTS);

  spa_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]   mark_r, mark_nxt;
  logic [CNT_W-1:0]   holes_r, holes_nxt;
  logic [IDX_W-1:0]   tgt_r, tgt_nxt;
  logic               op_free_r, op_free_nxt;
  logic [WADDR_W-1:0] scan_word_r, scan_word_nxt;
  logic [WADDR_W-1:0] last_word_r, last_word_nxt;
  logic               out_valid_r;
  logic               out_ok_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic [CNT_W-1:0]   out_hw_r;
  logic [CNT_W-1:0]   out_holes_r;

  logic               accept;
  logic               emit;
  logic               res_ok;
  logic [SLOT_W-1:0]  res_slot;
  logic               rd_en;
  logic [WADDR_W-1:0] rd_addr;
  logic               wr_en;
  logic [WADDR_W-1:0] wr_addr;
  logic [WORD_W-1:0]  wr_data;
  logic [WORD_W-1:0]  rd_data;
  logic [WORD_W-1:0]  tgt_bit;
  logic [IDX_W-1:0]   slot_x;
  logic [IDX_W-1:0]   mark_idx;
  logic [IDX_W-1:0]   mark_m1;
  logic [IDX_W:0]     mark_x;
  logic [IDX_W:0]     lim;
  spa_find_t          find;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  assign slot_x   = IDX_W'(in_slot);
  assign mark_idx = IDX_W'(mark_r);
  assign mark_m1  = IDX_W'(mark_r - CNT_W'(1));
  assign mark_x   = (IDX_W + 1)'(mark_r);
  assign tgt_bit  = WORD_W'(1) << tgt_r[BIT_W-1:0];

  // slots of the current scan word that lie below the mark
  assign lim = mark_x - {1'b0, scan_word_r, BIT_W'(0)};

  // used bitmap, one word per 16 slots
  spa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS),
    .AW    (WADDR_W)
  ) u_bitmap (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // lowest free slot below the mark in the word just read
  spa_find #(
    .LIM_W (IDX_W + 1)
  ) u_find (
    .word_i (rd_data),
    .lim_i  (lim),
    .find_o (find)
  );

  assign rd_en = accept || (state_r == ST_SCAN);

  // request sequencer
  always_comb begin
    state_nxt     = state_r;
    mark_nxt      = mark_r;
    holes_nxt     = holes_r;
    tgt_nxt       = tgt_r;
    op_free_nxt   = op_free_r;
    scan_word_nxt = scan_word_r;
    last_word_nxt = last_word_r;
    emit          = 1'b0;
    res_ok        = 1'b0;
    res_slot      = '0;
    wr_en         = 1'b0;
    wr_addr       = scan_word_r;
    wr_data       = rd_data;
    rd_addr       = scan_word_r + WADDR_W'(1);
    unique case (state_r)
      ST_IDLE: begin
        rd_addr = '0;
        if (accept) begin
          unique case (in_kind)
            KIND_ALLOC: begin
              if (holes_r == '0) begin
                rd_addr = mark_idx[IDX_W-1:BIT_W];
                if (mark_x >= POOL_X) begin
                  emit = 1'b1;
                end else begin
                  tgt_nxt     = mark_idx;
                  op_free_nxt = 1'b0;
                  state_nxt   = ST_UPDATE;
                end
              end else if (mark_r == '0) begin
                // holes counted but nothing below the mark
                holes_nxt = '0;
                emit      = 1'b1;
              end else begin
                scan_word_nxt = '0;
                last_word_nxt = mark_m1[IDX_W-1:BIT_W];
                state_nxt     = ST_SCAN;
              end
            end
            KIND_FREE: begin
              rd_addr = slot_x[IDX_W-1:BIT_W];
              if ((IDX_W + 1)'(in_slot) >= POOL_X) begin
                emit = 1'b1;
              end else begin
                tgt_nxt     = slot_x;
                op_free_nxt = 1'b1;
                state_nxt   = ST_UPDATE;
              end
            end
            KIND_CLEAR: begin
              mark_nxt  = '0;
              holes_nxt = '0;
              res_ok    = 1'b1;
              emit      = 1'b1;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      ST_UPDATE: begin
        wr_en     = 1'b1;
        wr_addr   = tgt_r[IDX_W-1:BIT_W];
        emit      = 1'b1;
        res_ok    = 1'b1;
        state_nxt = ST_IDLE;
        if (op_free_r) begin
          wr_data = rd_data & ~tgt_bit;
          if (mark_r != '0 && ((IDX_W + 1)'(tgt_r) + (IDX_W + 1)'(1)) == mark_x) begin
            mark_nxt = mark_r - CNT_W'(1);
          end else if ((IDX_W + 1)'(holes_r) < POOL_X) begin
            holes_nxt = holes_r + CNT_W'(1);
          end
        end else begin
          wr_data  = rd_data | tgt_bit;
          mark_nxt = mark_r + CNT_W'(1);
          res_slot = SLOT_W'(tgt_r);
        end
      end
      ST_SCAN: begin
        if (find.found) begin
          wr_en     = 1'b1;
          wr_data   = rd_data | (WORD_W'(1) << find.bit_idx);
          holes_nxt = holes_r - CNT_W'(1);
          emit      = 1'b1;
          res_ok    = 1'b1;
          res_slot  = SLOT_W'({scan_word_r, find.bit_idx});
          state_nxt = ST_IDLE;
        end else if (scan_word_r == last_word_r) begin
          // no hole found below the mark
          holes_nxt = '0;
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          scan_word_nxt = scan_word_r + WADDR_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mark_r      <= '0;
      holes_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mark_r      <= mark_nxt;
      holes_r     <= holes_nxt;
      out_valid_r <= emit;
    end
  end

  // request context and result payload
  always_ff @(posedge clk) begin
    tgt_r       <= tgt_nxt;
    op_free_r   <= op_free_nxt;
    scan_word_r <= scan_word_nxt;
    last_word_r <= last_word_nxt;
    if (emit) begin
      out_ok_r    <= res_ok;
      out_slot_r  <= res_slot;
      out_hw_r    <= mark_nxt;
      out_holes_r <= holes_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_ok           = out_ok_r;
  assign out_granted_slot = out_slot_r;
  assign out_high_water   = out_hw_r;
  assign out_hole_count   = out_holes_r;

endmodule

`default_nettype wire

/* rtl/spa_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module spa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/spa_find.sv */
`timescale 1ns / 1ps
`default_nettype none

module spa_find #(
  parameter int LIM_W = 8
) (
  input  wire logic [spa_pkg::WORD_W-1:0] word_i,
  input  wire logic [LIM_W-1:0]           lim_i,
  output spa_pkg::spa_find_t              find_o
);

  import spa_pkg::*;

  logic [WORD_W-1:0] cand;
  logic [WORD_W-1:0] lowest;
  logic [BIT_W-1:0]  idx;

  // free slots that lie below the mark
  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      cand[b] = !word_i[b] && (LIM_W'(b) < lim_i);
    end
  end

  // isolate the lowest candidate and encode it
  assign lowest = cand & (~cand + WORD_W'(1));

  always_comb begin
    idx = '0;
    for (int b = 0; b < WORD_W; b++) begin
      if (lowest[b]) begin
        idx = idx | BIT_W'(b);
      end
    end
  end

  assign find_o.found   = |cand;
  assign find_o.bit_idx = idx;

endmodule

`default_nettype wire

/* rtl/spa_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module spa_checker #(
  parameter int POOL_SLOTS = 64,
  parameter int SLOT_W     = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1,
  parameter int CNT_W      = $clog2(POOL_SLOTS + 1)
) (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic [1:0]        in_kind,
  input wire logic [SLOT_W-1:0] in_slot,
  input wire logic              out_valid,
  input wire logic              out_ok,
  input wire logic [SLOT_W-1:0] out_granted_slot,
  input wire logic [CNT_W-1:0]  out_high_water,
  input wire logic [CNT_W-1:0]  out_hole_count
);

  import spa_pkg::*;

  localparam logic [CNT_W:0] POOL_C = (CNT_W + 1)'(POOL_SLOTS);

  logic accept;
  logic free_ok;

  assign accept  = start && !busy;
  assign free_ok = accept && (in_kind == KIND_FREE) && ((CNT_W + 1)'(in_slot) < POOL_C);

  // counters never pass the pool size
  `SPA_ASSERT_NOW(a_cnt_range, clk, rst_n, out_valid, ((CNT_W + 1)'(out_high_water) <= POOL_C) && ((CNT_W + 1)'(out_hole_count) <= POOL_C))

  // a failed request hands out no slot
  `SPA_ASSERT_NOW(a_fail_slot, clk, rst_n, out_valid && !out_ok, out_granted_slot == '0)

  // clear answers in the next cycle with both counters zero
  `SPA_ASSERT_NEXT(a_clear, clk, rst_n, accept && (in_kind == KIND_CLEAR), out_valid && out_ok && out_high_water == '0 && out_hole_count == '0 && !busy)

  // a legal free does not answer at once: the block is busy with its read-modify-write
  `SPA_ASSERT_NEXT(a_free_rmw, clk, rst_n, free_ok, busy && !out_valid)

endmodule

bind slot_pool_allocator spa_checker #(
  .POOL_SLOTS (POOL_SLOTS),
  .SLOT_W     (SLOT_W),
  .CNT_W      (CNT_W)
) u_spa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_kind          (in_kind),
  .in_slot          (in_slot),
  .out_valid        (out_valid),
  .out_ok           (out_ok),
  .out_granted_slot (out_granted_slot),
  .out_high_water   (out_high_water),
  .out_hole_count   (out_hole_count)
);

`default_nettype wire

/* sim/slot_pool_allocator_tb.sv */
`timescale 1ns / 1ps

module slot_pool_allocator_tb;

  import spa_pkg::*;

  localparam int POOL       = 64;
  localparam int RAND_ITEMS = 1300;
  localparam int SETTLE     = 16;
  localparam int LIMIT      = 200000;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // one result item as the block reports it
  typedef struct packed {
    logic       ok;
    logic [5:0] granted;
    logic [6:0] hw;
    logic [6:0] holes;
  } pool_result_t;

  // one directed request, with its expected result when it is obvious
  typedef struct packed {
    logic [1:0]   kind;
    logic [5:0]   slot;
    logic         typed;
    pool_result_t res;
  } dir_row_t;

  typedef enum int {EP_MIXED, EP_FILL, EP_DRAIN, EP_STORM} episode_t;

  localparam pool_result_t NO_RES = '0;
  localparam int DIR_N = 21;
  localparam dir_row_t DIRECTED [DIR_N] = '{
    '{KIND_ALLOC,  6'd0,  1'b1, '{1'b1, 6'd0, 7'd1, 7'd0}},  // first grant after reset
    '{KIND_FREE,   6'd0,  1'b1, '{1'b1, 6'd0, 7'd0, 7'd0}},  // topmost slot lowers the mark
    '{KIND_FREE,   6'd5,  1'b1, '{1'b1, 6'd0, 7'd0, 7'd1}},  // mark at zero counts a hole
    '{KIND_ALLOC,  6'd63, 1'b1, '{1'b0, 6'd0, 7'd0, 7'd0}},  // no hole found, count cleared
    '{KIND_UNUSED, 6'd63, 1'b1, '{1'b0, 6'd0, 7'd0, 7'd0}},  // unknown kind ignored
    '{KIND_ALLOC,  6'd0,  1'b1, '{1'b1, 6'd0, 7'd1, 7'd0}},
    '{KIND_ALLOC,  6'd0,  1'b0, NO_RES},
    '{KIND_ALLOC,  6'd0,  1'b0, NO_RES},
    '{KIND_ALLOC,  6'd0,  1'b0, NO_RES},
    '{KIND_FREE,   6'd1,  1'b0, NO_RES},                     // holes below the mark
    '{KIND_FREE,   6'd2,  1'b0, NO_RES},
    '{KIND_FREE,   6'd63, 1'b0, NO_RES},                     // slot above the mark
    '{KIND_FREE,   6'd1,  1'b0, NO_RES},                     // slot already free
    '{KIND_ALLOC,  6'd0,  1'b0, NO_RES},                     // allocations into holes
    '{KIND_ALLOC,  6'd0,  1'b0, NO_RES},
    '{KIND_ALLOC,  6'd0,  1'b0, NO_RES},                     // stale hole count, fails
    '{KIND_ALLOC,  6'd0,  1'b0, NO_RES},
    '{KIND_FREE,   6'd4,  1'b0, NO_RES},
    '{KIND_CLEAR,  6'd63, 1'b1, '{1'b1, 6'd0, 7'd0, 7'd0}},
    '{KIND_FREE,   6'd63, 1'b0, NO_RES},
    '{KIND_CLEAR,  6'd0,  1'b1, '{1'b1, 6'd0, 7'd0, 7'd0}}
  };

  logic       clk;
  logic       rst_n   = 1'b0;
  logic       start   = 1'b0;
  logic [1:0] in_kind = KIND_ALLOC;
  logic [5:0] in_slot = 6'd0;
  logic       busy;
  logic       out_valid;
  logic       out_ok;
  logic [5:0] out_granted_slot;
  logic [6:0] out_high_water;
  logic [6:0] out_hole_count;

  // shadow of the pool state
  logic [POOL-1:0] used_map = '0;
  logic [6:0]      mark_q   = '0;
  logic [6:0]      holes_q  = '0;

  pool_result_t grant_q [$];
  pool_result_t want_res;
  int fail_count  = 0;
  int cycle_count = 0;
  int sent_count  = 0;
  int seen_count  = 0;
  int idle_pct    = 0;
  int full_misses = 0;
  int sat_hits    = 0;
  int hole_grants = 0;
  int scan_misses = 0;

  slot_pool_allocator i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_slot          (in_slot),
    .out_valid        (out_valid),
    .out_ok           (out_ok),
    .out_granted_slot (out_granted_slot),
    .out_high_water   (out_high_water),
    .out_hole_count   (out_hole_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // update the shadow pool for one request and return what the block should report
  function automatic pool_result_t predict_request(input logic [1:0] k, input logic [5:0] s);
    pool_result_t r;
    logic         hit;
    r   = '0;
    hit = 1'b0;
    case (k)
      KIND_ALLOC: begin
        if (holes_q == 0) begin
          if (mark_q < POOL) begin
            used_map[mark_q] = 1'b1;
            r.ok      = 1'b1;
            r.granted = mark_q[5:0];
            mark_q    = mark_q + 7'd1;
          end else begin
            full_misses++;
          end
        end else begin
          // lowest free slot below the mark
          for (int i = 0; i < POOL; i++) begin
            if (!hit && i < mark_q && !used_map[i]) begin
              hit         = 1'b1;
              used_map[i] = 1'b1;
              holes_q     = holes_q - 7'd1;
              r.ok        = 1'b1;
              r.granted   = i[5:0];
            end
          end
          if (hit) hole_grants++;
          else begin
            holes_q = '0;
            scan_misses++;
          end
        end
      end
      KIND_FREE: begin
        if (mark_q != 0 && {1'b0, s} == mark_q - 7'd1) mark_q = mark_q - 7'd1;
        else if (holes_q < POOL) holes_q = holes_q + 7'd1;
        else sat_hits++;
        used_map[s] = 1'b0;
        r.ok        = 1'b1;
      end
      KIND_CLEAR: begin
        mark_q  = '0;
        holes_q = '0;
        r.ok    = 1'b1;
      end
      default: ;
    endcase
    r.hw    = mark_q;
    r.holes = holes_q;
    return r;
  endfunction

  // drive one request and wait for it to be taken; start is left high
  task automatic send_request(input logic [1:0] k, input logic [5:0] s,
                              input logic typed, input pool_result_t typed_res);
    pool_result_t r;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start   <= 1'b1;
    in_kind <= k;
    in_slot <= s;
    do @(posedge clk); while (busy);
    r = predict_request(k, s);
    grant_q.push_back(typed ? typed_res : r);
    sent_count++;
  endtask

  // hold the sender off until every outstanding result is back
  task automatic drain_results();
    start <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk);
  endtask

  // a slot that is in use below the mark, or any slot when none is
  function automatic logic [5:0] pick_used_slot();
    int          first;
    int          idx;
    logic        hit;
    logic [5:0]  s;
    first = $urandom_range(POOL - 1);
    hit   = 1'b0;
    s     = 6'($urandom_range(POOL - 1));
    for (int j = 0; j < POOL; j++) begin
      idx = (first + j) % POOL;
      if (!hit && idx < mark_q && used_map[idx]) begin
        hit = 1'b1;
        s   = idx[5:0];
      end
    end
    return s;
  endfunction

  // choose the next request of an episode
  task automatic pick_request(input episode_t mode, output logic [1:0] k, output logic [5:0] s);
    int roll;
    int alloc_pct;
    int free_pct;
    roll = $urandom_range(99);
    s    = 6'($urandom_range(POOL - 1));
    case (mode)
      EP_FILL:  begin alloc_pct = 85; free_pct = 95; end
      EP_DRAIN: begin alloc_pct = 25; free_pct = 90; end
      EP_STORM: begin alloc_pct = 0;  free_pct = 0;  end
      default:  begin alloc_pct = 50; free_pct = 88; end
    endcase
    if (mode == EP_STORM) begin
      k = KIND_FREE;
    end else if (roll < alloc_pct) begin
      k = KIND_ALLOC;
    end else if (roll < free_pct) begin
      k = KIND_FREE;
      if (mode == EP_DRAIN && mark_q != 0 && $urandom_range(2) == 0) s = 6'(mark_q - 7'd1);
      else s = pick_used_slot();
    end else begin
      // noise: clears, unknown kinds, frees of arbitrary slots
      roll = $urandom_range(9);
      if (roll == 0) k = KIND_CLEAR;
      else if (roll < 3) k = KIND_UNUSED;
      else k = KIND_FREE;
    end
  endtask

  // one run of requests in a given mix
  task automatic run_episode(input episode_t mode);
    int         n;
    logic [1:0] k;
    logic [5:0] s;
    case (mode)
      EP_FILL:  n = $urandom_range(120, 60);
      EP_STORM: n = 72;
      default:  n = $urandom_range(80, 16);
    endcase
    if (mode == EP_STORM) send_request(KIND_CLEAR, 6'($urandom_range(POOL - 1)), 1'b0, NO_RES);
    repeat (n) begin
      pick_request(mode, k, s);
      send_request(k, s, 1'b0, NO_RES);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (grant_q.size() == 0) begin
        $error("result item with no request outstanding");
        fail_count++;
      end else begin
        want_res = grant_q.pop_front();
        seen_count++;
        if (out_ok !== want_res.ok) begin
          $error("ok: expected %0d, got %0d", want_res.ok, out_ok);
          fail_count++;
        end
        if (out_granted_slot !== want_res.granted) begin
          $error("granted_slot: expected %0d, got %0d", want_res.granted, out_granted_slot);
          fail_count++;
        end
        if (out_high_water !== want_res.hw) begin
          $error("high_water: expected %0d, got %0d", want_res.hw, out_high_water);
          fail_count++;
        end
        if (out_hole_count !== want_res.holes) begin
          $error("hole_count: expected %0d, got %0d", want_res.holes, out_hole_count);
          fail_count++;
        end
      end
    end
  end

  // stimulus
  initial begin : stimulus
    int       idle_plan [4];
    int       goal;
    int       roll;
    episode_t mode;
    idle_plan = '{0, 45, 23, 0};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed requests
    for (int r = 0; r < DIR_N; r++) begin
      send_request(DIRECTED[r].kind, DIRECTED[r].slot, DIRECTED[r].typed, DIRECTED[r].res);
    end
    drain_results();

    // random episodes, in phases of sender idling
    for (int p = 0; p < 4; p++) begin
      idle_pct = idle_plan[p];
      goal     = DIR_N + (p + 1) * RAND_ITEMS / 4;
      if (p == 0) begin
        run_episode(EP_FILL);
        run_episode(EP_FILL);
        run_episode(EP_STORM);
      end
      while (sent_count < goal) begin
        roll = $urandom_range(9);
        if (roll == 0) mode = EP_STORM;
        else if (roll < 4) mode = EP_FILL;
        else if (roll < 6) mode = EP_DRAIN;
        else mode = EP_MIXED;
        run_episode(mode);
      end
      drain_results();
    end

    repeat (SETTLE) @(posedge clk);
    if (grant_q.size() != 0) begin
      $error("%0d result items never arrived", grant_q.size());
      fail_count++;
    end

    $display("%0d requests sent, %0d results checked", sent_count, seen_count);
    $display("full-pool misses %0d, hole grants %0d, empty scans %0d, saturated frees %0d",
             full_misses, hole_grants, scan_misses, sat_hits);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/spa_pkg.sv
rtl/spa_ram.sv
rtl/spa_find.sv
rtl/slot_pool_allocator.sv
rtl/spa_checker.sv
sim/slot_pool_allocator_tb.sv
